### rtl/core/glcd_pkg.sv
// Shared types and constants of the two-chip graphic LCD controller.
package glcd_pkg;

	localparam int COLUMNS    = 64;
	localparam int PAGES      = 8;
	localparam int COL_W      = $clog2(COLUMNS);
	localparam int PAGE_W     = $clog2(PAGES);
	localparam int CHIP_DEPTH = PAGES * COLUMNS;
	localparam int ADDR_W     = $clog2(CHIP_DEPTH);
	localparam int START_W    = 6;
	localparam int BYTE_W     = 8;

	// Access kinds.
	localparam logic [1:0] KIND_INSTR = 2'd0;
	localparam logic [1:0] KIND_WRITE = 2'd1;
	localparam logic [1:0] KIND_READ  = 2'd2;

	// Instruction opcodes, taken from the top two bits of the byte.
	localparam logic [1:0] OP_DISPLAY = 2'b00;
	localparam logic [1:0] OP_COLUMN  = 2'b01;
	localparam logic [1:0] OP_PAGE    = 2'b10;
	localparam logic [1:0] OP_START   = 2'b11;

	typedef struct packed {
		logic [1:0]        kind;
		logic              chip1_select;
		logic              chip2_select;
		logic [BYTE_W-1:0] data;
	} cmd_t;

	typedef struct packed {
		logic [BYTE_W-1:0] read_data;
		logic              read_valid;
		logic              display_on;
	} result_t;

	typedef enum logic [1:0] {
		ST_CLEAR = 2'b01,
		ST_RUN   = 2'b10
	} state_t;

endpackage

### rtl/core/glcd_ram.sv
// Generic single-port synchronous RAM with registered read data.
module glcd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata_q <= mem_q[addr];
	end

	assign rdata = rdata_q;

endmodule

### rtl/core/dual_chip_glcd_controller_unit.sv
// Top level of the two-chip 128x64 graphic LCD controller.
// The result beat for an access shows on done in the cycle after start is taken.
// Throughput: one access per cycle unless busy; each RAM is read or written once per access.
// Reset: arst_n clears all address, start-line and display registers at once; then a
// clearing pass zeroes every address of both display RAMs while busy is high.
// The receiver cannot stall: every result beat is taken in the cycle it is shown.
module dual_chip_glcd_controller_unit
	import glcd_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	output logic    busy,
	input  cmd_t    cmd,
	output logic    done,
	output result_t result
);

	// Control state: a clearing pass after reset, then normal operation.
	state_t            state_q;
	logic [ADDR_W-1:0] clr_addr_q;

	// Per-chip position registers. Index 0 is the left chip, index 1 the right chip.
	logic [COL_W-1:0]   col_q   [2];
	logic [PAGE_W-1:0]  page_q  [2];
	logic [START_W-1:0] start_q [2];
	logic               display_q;

	// Result pipeline: the RAM read data lines up with these registers.
	logic done_s1;
	logic valid_s1;
	logic chip2_s1;

	logic               acc;
	logic               clearing;
	logic [1:0]         sel;
	logic [1:0]         op;
	logic [ADDR_W-1:0]  ram_addr  [2];
	logic               ram_we    [2];
	logic [BYTE_W-1:0]  ram_wdata [2];
	logic [BYTE_W-1:0]  ram_rdata [2];

	assign clearing = (state_q == ST_CLEAR);
	assign busy     = clearing;
	assign acc      = start && !busy;
	assign sel      = {cmd.chip2_select, cmd.chip1_select};
	assign op       = cmd.data[BYTE_W-1:BYTE_W-2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_addr_q <= '0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (clr_addr_q == ADDR_W'(CHIP_DEPTH - 1)) begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					state_q <= ST_RUN;
				end
				default: begin
					state_q <= ST_CLEAR;
				end
			endcase
		end
	end

	// Each chip owns one display RAM, addressed by page and column. A data write
	// stores at the current position; a read fetches from it. Either way the column
	// then advances and wraps from the last column to the first on the same page.
	for (genvar c = 0; c < 2; c++) begin : g_chip
		logic move;

		assign move = acc && sel[c] && (cmd.kind == KIND_WRITE || cmd.kind == KIND_READ);

		assign ram_addr[c]  = clearing ? clr_addr_q : {page_q[c], col_q[c]};
		assign ram_we[c]    = clearing || (acc && sel[c] && cmd.kind == KIND_WRITE);
		assign ram_wdata[c] = clearing ? '0 : cmd.data;

		glcd_ram #(
			.WIDTH(BYTE_W),
			.DEPTH(CHIP_DEPTH)
		) u_ram (
			.clk  (clk),
			.we   (ram_we[c]),
			.addr (ram_addr[c]),
			.wdata(ram_wdata[c]),
			.rdata(ram_rdata[c])
		);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				col_q[c]   <= '0;
				page_q[c]  <= '0;
				start_q[c] <= '0;
			end else if (acc && sel[c] && cmd.kind == KIND_INSTR) begin
				case (op)
					OP_COLUMN: col_q[c]   <= cmd.data[COL_W-1:0];
					OP_PAGE:   page_q[c]  <= cmd.data[PAGE_W-1:0];
					OP_START:  start_q[c] <= cmd.data[START_W-1:0];
					default:   col_q[c]   <= col_q[c];
				endcase
			end else if (move) begin
				col_q[c] <= col_q[c] + 1'b1;
			end
		end
	end

	// The display flag is global and ignores the chip selects.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			display_q <= 1'b0;
		end else if (acc && cmd.kind == KIND_INSTR && op == OP_DISPLAY) begin
			display_q <= cmd.data[0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s1  <= 1'b0;
			valid_s1 <= 1'b0;
			chip2_s1 <= 1'b0;
		end else begin
			done_s1  <= acc;
			valid_s1 <= acc && cmd.kind == KIND_READ && (sel != 2'b00);
			chip2_s1 <= sel[1];
		end
	end

	// When both chips are read, the right chip's byte is the one returned.
	assign done              = done_s1;
	assign result.read_data  = valid_s1 ? (chip2_s1 ? ram_rdata[1] : ram_rdata[0]) : '0;
	assign result.read_valid = valid_s1;
	assign result.display_on = display_q;

`ifndef SYNTHESIS
	// A result beat is shown only for an access taken in the previous cycle.
	a_done_follows_accept: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy))
		else $error("result beat without an accepted access");

	// No result beat can appear while the display RAMs are being cleared.
	a_no_done_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !done)
		else $error("result beat during the clearing pass");

	// The start line of a chip changes only through an accepted instruction write.
	a_start_line_instr: assert property (@(posedge clk) disable iff (!arst_n)
		(start_q[0] != $past(start_q[0]) || start_q[1] != $past(start_q[1]))
		|-> $past(start && !busy && cmd.kind == KIND_INSTR))
		else $error("start line changed without an instruction write");

	// The display flag changes only through an accepted instruction write.
	a_display_instr: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(display_q) |-> $past(start && !busy && cmd.kind == KIND_INSTR))
		else $error("display flag changed without an instruction write");
`endif

endmodule
